@@ hdl/kissd_pkg.sv @@
// Shared codes, result kinds and record types for the KISS receive deframer.
package kissd_pkg;

	localparam logic [7:0] FEND  = 8'hC0;
	localparam logic [7:0] FESC  = 8'hDB;
	localparam logic [7:0] TFEND = 8'hDC;
	localparam logic [7:0] TFESC = 8'hDD;
	localparam logic [7:0] TYPE_RETURN = 8'hFF;

	// widest byte count needed over the whole range of frame sizes (up to 4096)
	localparam int CNT_EXT_W = 13;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ABORT = 2'd2
	} kind_t;

	typedef struct packed {
		logic in_frame;
		logic escape_armed;
	} flags_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [8:0]  byte_index;
		logic [9:0]  frame_length;
		logic [3:0]  port;
		logic [3:0]  command;
		logic        is_return;
	} result_t;

endpackage

@@ hdl/kissd_rx_if.sv @@
// Stream channels: raw received bytes in, decoded results out.
interface kissd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface kissd_tx_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [8:0]  byte_index;
	logic [9:0]  frame_length;
	logic [3:0]  port;
	logic [3:0]  command;
	logic        is_return;

	modport source (output valid, output kind, output data_byte, output byte_index,
		output frame_length, output port, output command, output is_return, input ready);
	modport sink   (input valid, input kind, input data_byte, input byte_index,
		input frame_length, input port, input command, input is_return, output ready);
endinterface

@@ hdl/kissd_decode.sv @@
// Per-byte KISS decode: next frame state and the result for one received byte.
module kissd_decode
	import kissd_pkg::*;
#(
	parameter int MAX_BYTES = 512,
	parameter int CNT_W     = 10
) (
	input  logic [7:0]       rx_byte,
	input  flags_t           flags,
	input  logic [CNT_W-1:0] count,
	input  logic [7:0]       type_value,
	output logic             res_valid,
	output result_t          res,
	output flags_t           flags_next,
	output logic [CNT_W-1:0] count_next,
	output logic [7:0]       type_next
);

	logic [CNT_EXT_W-1:0] count_ext;
	logic                 full;
	logic                 nonempty;
	logic                 have_byte;
	logic [7:0]           dec_byte;
	result_t              report;

	assign count_ext = CNT_EXT_W'(count);
	assign full      = (count == CNT_W'(MAX_BYTES));
	assign nonempty  = (count != '0);

	always_comb begin
		report              = '0;
		report.frame_length = count_ext[9:0];
		report.port         = type_value[7:4];
		report.command      = type_value[3:0];
		report.is_return    = (type_value == TYPE_RETURN);
	end

	always_comb begin
		res_valid  = 1'b0;
		res        = '0;
		flags_next = flags;
		count_next = count;
		type_next  = type_value;
		have_byte  = 1'b0;
		dec_byte   = rx_byte;

		priority if (rx_byte == FEND) begin
			if (flags.in_frame && nonempty) begin
				res_valid = 1'b1;
				res       = report;
				res.kind  = KIND_DONE;
			end
			count_next              = '0;
			flags_next.escape_armed = 1'b0;
			flags_next.in_frame     = 1'b1;
		end else if (!flags.in_frame) begin
			// ignore bytes between frames
		end else if (rx_byte == FESC) begin
			flags_next.escape_armed = 1'b1;
		end else if (flags.escape_armed) begin
			flags_next.escape_armed = 1'b0;
			// drop any escaped byte other than the two transposed codes
			if (rx_byte == TFEND) begin
				dec_byte  = FEND;
				have_byte = 1'b1;
			end else if (rx_byte == TFESC) begin
				dec_byte  = FESC;
				have_byte = 1'b1;
			end
		end else begin
			have_byte = 1'b1;
		end

		if (have_byte) begin
			res_valid = 1'b1;
			if (!full) begin
				res.kind       = KIND_BYTE;
				res.data_byte  = dec_byte;
				res.byte_index = count_ext[8:0];
				if (!nonempty) begin
					type_next = dec_byte;
				end
				count_next = count + CNT_W'(1);
			end else begin
				// overflow: report and leave the frame until the next FEND
				res                     = report;
				res.kind                = KIND_ABORT;
				count_next              = '0;
				flags_next.escape_armed = 1'b0;
				flags_next.in_frame     = 1'b0;
			end
		end
	end

endmodule

@@ hdl/kiss_deframer.sv @@
// KISS receive deframer: one raw byte per beat in, at most one result per byte out.
// Each accepted byte is registered in the input stage, and its result in the result stage behind it.
// Throughput: one byte per cycle while results are taken; the input stage advances whenever the result slot is free
// or is being taken in the same cycle, so back-pressure holds the result and stalls the input stage.
// Reset (arst_n low, asynchronous) closes any frame, clears escape, count and type byte,
// and empties both stages.
module kiss_deframer
	import kissd_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	kissd_rx_if.sink          rx,
	kissd_tx_if.source        tx
);

	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;

	flags_t           flags_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       type_q;

	logic             res_valid;
	result_t          res;
	flags_t           flags_next;
	logic [CNT_W-1:0] count_next;
	logic [7:0]       type_next;

	logic             out_valid_q;
	result_t          out_q;

	assign advance  = !out_valid_q || tx.ready;
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	kissd_decode #(
		.MAX_BYTES (MAX_FRAME_BYTES),
		.CNT_W     (CNT_W)
	) u_decode (
		.rx_byte    (byte_s1),
		.flags      (flags_q),
		.count      (count_q),
		.type_value (type_q),
		.res_valid  (res_valid),
		.res        (res),
		.flags_next (flags_next),
		.count_next (count_next),
		.type_next  (type_next)
	);

	// commit frame state only when the staged byte moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			count_q <= '0;
			type_q  <= '0;
		end else if (valid_s1 && advance) begin
			flags_q <= flags_next;
			count_q <= count_next;
			type_q  <= type_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			out_q <= res;
		end
	end

	assign tx.valid        = out_valid_q;
	assign tx.kind         = out_q.kind;
	assign tx.data_byte    = out_q.data_byte;
	assign tx.byte_index   = out_q.byte_index;
	assign tx.frame_length = out_q.frame_length;
	assign tx.port         = out_q.port;
	assign tx.command      = out_q.command;
	assign tx.is_return    = out_q.is_return;

endmodule

@@ tb/kiss_deframer_tb.sv @@
// Self-checking testbench for the KISS receive deframer: directed and random byte streams.
module kiss_deframer_tb
	import kissd_pkg::*;
();

	localparam int MAX_BYTES  = 512;
	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD  = 300;

	logic clk;
	logic arst_n;

	kissd_rx_if rx_ch ();
	kissd_tx_if tx_ch ();

	kiss_deframer #(.MAX_FRAME_BYTES(MAX_BYTES)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch.sink),
		.tx     (tx_ch.source)
	);

	// predictor state
	bit         frame_open;
	bit         esc_pending;
	int         held_count;
	logic [7:0] frame_type;

	result_t want_q[$];

	int  errors;
	int  bytes_sent;
	int  idle_cycles;
	bit  idle_on;
	bit  stall_on;
	bit  long_hold_req;
	int  hold_left;

	always #2 clk = ~clk;

	function automatic result_t frame_report(input kind_t k);
		result_t r;
		r = '0;
		r.kind         = k;
		r.frame_length = 10'(held_count);
		r.port         = frame_type[7:4];
		r.command      = frame_type[3:0];
		r.is_return    = (frame_type == TYPE_RETURN);
		return r;
	endfunction

	// Work out the result, if any, caused by one accepted raw byte.
	task automatic kiss_predict(input logic [7:0] b);
		result_t    r;
		logic [7:0] d;
		bit         dropped;
		r       = '0;
		d       = b;
		dropped = 0;
		if (b == FEND) begin
			if (frame_open && held_count > 0)
				want_q.push_back(frame_report(KIND_DONE));
			held_count  = 0;
			esc_pending = 0;
			frame_open  = 1;
		end else if (frame_open) begin
			if (b == FESC) begin
				esc_pending = 1;
			end else begin
				if (esc_pending) begin
					esc_pending = 0;
					if (b == TFEND)
						d = FEND;
					else if (b == TFESC)
						d = FESC;
					else
						dropped = 1;
				end
				if (!dropped) begin
					if (held_count < MAX_BYTES) begin
						if (held_count == 0)
							frame_type = d;
						r.kind       = KIND_BYTE;
						r.data_byte  = d;
						r.byte_index = 9'(held_count);
						want_q.push_back(r);
						held_count++;
					end else begin
						// overflow: report and leave the frame until the next FEND
						want_q.push_back(frame_report(KIND_ABORT));
						held_count  = 0;
						esc_pending = 0;
						frame_open  = 0;
					end
				end
			end
		end
	endtask

	// Offer one raw byte; returns at the falling edge after its beat.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (idle_on && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 12);
			rx_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		kiss_predict(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Escape a decoded value onto the line.
	task automatic send_escaped(input logic [7:0] v);
		if (v == FEND) begin
			send_byte(FESC);
			send_byte(TFEND);
		end else if (v == FESC) begin
			send_byte(FESC);
			send_byte(TFESC);
		end else begin
			send_byte(v);
		end
	endtask

	function automatic logic [7:0] pick_value();
		case ($urandom_range(0, 11))
			0: return FEND;
			1: return FESC;
			2: return TFEND;
			3: return TFESC;
			4: return TYPE_RETURN;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_noise();
		case ($urandom_range(0, 3))
			0: begin
				send_byte(FESC);
				send_byte(8'($urandom_range(0, 255)));
			end
			1: begin
				send_byte(FESC);
				send_byte(FESC);
			end
			2: send_byte(FEND);
			default: send_byte(8'($urandom_range(0, 255)));
		endcase
	endtask

	// Opening FEND, then n decoded values (with random noise if noisy); the next frame's FEND closes it.
	task automatic send_frame(input int n, input bit noisy);
		logic [7:0] v;
		send_byte(FEND);
		for (int i = 0; i < n; i++) begin
			v = pick_value();
			if (i == 0 && $urandom_range(0, 5) == 0)
				v = TYPE_RETURN;
			if (noisy && $urandom_range(0, 11) == 0)
				send_noise();
			send_escaped(v);
		end
	endtask

	task automatic run_random_frames(input int count);
		int stop_at;
		int n;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0: n = 0;
				1: n = $urandom_range(25, 60);
				default: n = $urandom_range(1, 12);
			endcase
			send_frame(n, $urandom_range(0, 3) == 0);
		end
		send_byte(FEND);
	endtask

	task automatic test_outside_and_empty();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(FESC);
		send_byte(TFEND);
		send_byte(FEND);
		send_byte(FEND);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'h01);
		send_byte(FEND);
	endtask

	task automatic test_escapes();
		send_byte(FESC);
		send_byte(TFEND);
		send_byte(FESC);
		send_byte(TFESC);
		send_byte(FESC);
		send_byte(8'h41);
		send_byte(FESC);
		send_byte(FESC);
		send_byte(TFESC);
		// escape then FEND: boundary, not data
		send_byte(FESC);
		send_byte(FEND);
		send_byte(TFEND);
		send_byte(FEND);
		send_byte(TYPE_RETURN);
		send_byte(8'h12);
		send_byte(FEND);
	endtask

	task automatic test_full_frame();
		for (int i = 0; i < MAX_BYTES; i++)
			send_escaped(8'($urandom_range(0, 255)));
		send_byte(FEND);
	endtask

	task automatic test_overflow();
		for (int i = 0; i < MAX_BYTES; i++)
			send_escaped(pick_value());
		send_byte(FESC);
		send_byte(TFEND);
		// out of frame now: all ignored until FEND
		send_byte(8'h33);
		send_byte(FESC);
		send_byte(TFEND);
		send_byte(8'hFF);
		send_byte(FEND);
		send_byte(8'hAB);
		send_byte(FEND);
	endtask

	task automatic test_backpressure();
		long_hold_req = 1;
		send_frame(60, 0);
		send_byte(FEND);
	endtask

	// Receiver: random stall bursts and one long hold on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			tx_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			tx_ch.ready <= 1'b0;
		end else if (long_hold_req) begin
			long_hold_req = 0;
			hold_left = LONG_HOLD - 1;
			tx_ch.ready <= 1'b0;
		end else if (stall_on && $urandom_range(0, 9) == 0) begin
			hold_left = $urandom_range(1, 12) - 1;
			tx_ch.ready <= 1'b0;
		end else begin
			tx_ch.ready <= 1'b1;
		end
	end

	task automatic note_error(input string what, input result_t want, input result_t got);
		errors++;
		if (errors <= 10) begin
			$write("%s: want kind=%0d data=%02h idx=%0d len=%0d port=%0h cmd=%0h ret=%0b, ",
				what, want.kind, want.data_byte, want.byte_index, want.frame_length,
				want.port, want.command, want.is_return);
			$display("got kind=%0d data=%02h idx=%0d len=%0d port=%0h cmd=%0h ret=%0b",
				got.kind, got.data_byte, got.byte_index, got.frame_length,
				got.port, got.command, got.is_return);
		end
	endtask

	always @(posedge clk) begin : check_result
		result_t got;
		result_t want;
		if (arst_n && tx_ch.valid && tx_ch.ready) begin
			got.kind         = kind_t'(tx_ch.kind);
			got.data_byte    = tx_ch.data_byte;
			got.byte_index   = tx_ch.byte_index;
			got.frame_length = tx_ch.frame_length;
			got.port         = tx_ch.port;
			got.command      = tx_ch.command;
			got.is_return    = tx_ch.is_return;
			if (want_q.size() == 0) begin
				note_error("unexpected beat", '0, got);
			end else begin
				want = want_q.pop_front();
				if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
					got.byte_index !== want.byte_index ||
					got.frame_length !== want.frame_length ||
					got.port !== want.port || got.command !== want.command ||
					got.is_return !== want.is_return)
					note_error("mismatch", want, got);
			end
		end
	end

	// Watchdog: count cycles with no beat on either side.
	always @(posedge clk) begin
		if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = 8'h00;
		frame_open    = 0;
		esc_pending   = 0;
		held_count    = 0;
		frame_type    = 8'h00;
		errors        = 0;
		bytes_sent    = 0;
		idle_cycles   = 0;
		idle_on       = 0;
		stall_on      = 0;
		long_hold_req = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_outside_and_empty();
		test_escapes();
		idle_on  = 1;
		stall_on = 1;
		test_full_frame();
		test_overflow();
		test_backpressure();
		run_random_frames(120);
		idle_on  = 0;
		stall_on = 0;
		run_random_frames(100);
		rx_ch.valid <= 1'b0;

		while (want_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
hdl/kissd_pkg.sv
hdl/kissd_rx_if.sv
hdl/kissd_decode.sv
hdl/kiss_deframer.sv
tb/kiss_deframer_tb.sv
